// File: design/dpbp_pkg.sv
// Shared constants, register map and helpers for the depth pixel back-projection unit.
// No dependencies; imported by dpbp_axis, depth_pixel_backprojection_unit and its testbench.
package dpbp_pkg;

    localparam int COORD_BITS = 12;
    localparam int DEPTH_BITS = 16;

    localparam int CENTER_W = 16;
    localparam int RECIP_W  = 25;
    localparam int COLOR_W  = 8;
    localparam int COORD_W  = 32;
    localparam int Z_W      = 16;
    localparam int FRAC_W   = 28;
    localparam int SPLIT_W  = 24;

    localparam int N_STAGES = 5;

    localparam int P_W   = COORD_BITS + 4;
    localparam int MAG_W = (P_W > CENTER_W) ? P_W : CENTER_W;
    localparam int A_W   = MAG_W + DEPTH_BITS;
    localparam int AH_W  = (A_W > SPLIT_W) ? (A_W - SPLIT_W) : 1;
    localparam int AX_W  = SPLIT_W + AH_W;
    localparam int HI_W  = AH_W + RECIP_W;
    localparam int LO_W  = SPLIT_W + RECIP_W;
    localparam int PART_W = LO_W + 1;
    localparam int PC_W  = PART_W - FRAC_W;
    localparam int HS_W  = HI_W - 4;
    localparam int R_W   = ((HS_W > PC_W) ? HS_W : PC_W) + 1;
    localparam int CMP_W = (R_W > COORD_W + 1) ? R_W : COORD_W + 1;
    localparam int ZC_W  = (DEPTH_BITS > Z_W) ? DEPTH_BITS : Z_W;

    localparam logic [CMP_W-1:0] SAT_POS = CMP_W'(64'h7FFF_FFFF);
    localparam logic [CMP_W-1:0] SAT_NEG = CMP_W'(64'h8000_0000);

    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    localparam logic [1:0] REG_CENTER_X = 2'd0;
    localparam logic [1:0] REG_CENTER_Y = 2'd1;
    localparam logic [1:0] REG_RECIP_X  = 2'd2;
    localparam logic [1:0] REG_RECIP_Y  = 2'd3;

    localparam logic [CENTER_W-1:0] RST_CENTER_X = CENTER_W'(3902);
    localparam logic [CENTER_W-1:0] RST_CENTER_Y = CENTER_W'(2207);
    localparam logic [RECIP_W-1:0]  RST_RECIP_X  = RECIP_W'(46602);
    localparam logic [RECIP_W-1:0]  RST_RECIP_Y  = RECIP_W'(46602);

    typedef struct packed {
        logic               pv;
        logic [Z_W-1:0]     z;
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
    } t_side;

    function automatic logic [Z_W-1:0] sat_depth(input logic [DEPTH_BITS-1:0] d);
        logic [ZC_W-1:0] dz;
        dz = ZC_W'(d);
        if (dz > ZC_W'({Z_W{1'b1}})) begin
            return {Z_W{1'b1}};
        end
        return dz[Z_W-1:0];
    endfunction

endpackage

// File: design/dpbp_axis.sv
// One back-projection axis: offset, depth product, split reciprocal product,
// rounding and saturation over five register stages. Depends on dpbp_pkg.
module dpbp_axis (
    input  logic                            i_clk,
    input  logic [dpbp_pkg::N_STAGES-1:0]   i_en,
    input  logic [dpbp_pkg::COORD_BITS-1:0] i_pix,
    input  logic [dpbp_pkg::DEPTH_BITS-1:0] i_depth,
    input  logic [dpbp_pkg::CENTER_W-1:0]   i_center,
    input  logic [dpbp_pkg::RECIP_W-1:0]    i_recip,
    output logic [dpbp_pkg::COORD_W-1:0]    o_coord
);
    import dpbp_pkg::*;

    logic [MAG_W-1:0]      w_p;
    logic [MAG_W-1:0]      w_c;
    logic                  w_neg;
    logic [AX_W-1:0]       w_ax;
    logic [PART_W-1:0]     w_part;
    logic [R_W-1:0]        w_r;
    logic [CMP_W-1:0]      w_rc;
    logic [CMP_W-1:0]      w_lim;
    logic [COORD_W-1:0]    w_rs;

    logic [MAG_W-1:0]      r_mag0;
    logic [DEPTH_BITS-1:0] r_depth0;
    logic [A_W-1:0]        r_a1;
    logic [HI_W-1:0]       r_hi2;
    logic [LO_W-1:0]       r_lo2;
    logic [HS_W-1:0]       r_hs3;
    logic [PC_W-1:0]       r_pc3;
    logic [COORD_W-1:0]    r_coord4;
    logic [N_STAGES-2:0]   r_neg;

    assign w_p   = MAG_W'({i_pix, 4'b0000});
    assign w_c   = MAG_W'(i_center);
    assign w_neg = w_p < w_c;
    assign w_ax  = AX_W'(r_a1);

    assign w_part = PART_W'(r_lo2) + (PART_W'(r_hi2[3:0]) << SPLIT_W)
                  + (PART_W'(1) << (FRAC_W - 1));

    assign w_r   = R_W'(r_hs3) + R_W'(r_pc3);
    assign w_rc  = CMP_W'(w_r);
    assign w_lim = r_neg[3] ? SAT_NEG : SAT_POS;
    assign w_rs  = (w_rc > w_lim) ? w_lim[COORD_W-1:0] : w_rc[COORD_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_neg[0] <= w_neg;
            r_mag0   <= w_neg ? (w_c - w_p) : (w_p - w_c);
            r_depth0 <= i_depth;
        end
        if (i_en[1]) begin
            r_neg[1] <= r_neg[0];
            r_a1     <= A_W'(r_mag0) * A_W'(r_depth0);
        end
        if (i_en[2]) begin
            r_neg[2] <= r_neg[1];
            r_hi2    <= HI_W'(w_ax[AX_W-1:SPLIT_W]) * HI_W'(i_recip);
            r_lo2    <= LO_W'(w_ax[SPLIT_W-1:0]) * LO_W'(i_recip);
        end
        if (i_en[3]) begin
            r_neg[3] <= r_neg[2];
            r_hs3    <= r_hi2[HI_W-1:4];
            r_pc3    <= w_part[PART_W-1:FRAC_W];
        end
        if (i_en[4]) begin
            r_coord4 <= r_neg[3] ? (COORD_W'(0) - w_rs) : w_rs;
        end
    end

    assign o_coord = r_coord4;

endmodule

// File: design/depth_pixel_backprojection_unit.sv
// Top level of the depth pixel back-projection unit: APB register file,
// pipeline flow control and side-band stages. Depends on dpbp_pkg, dpbp_axis.
//
// Usage: pixels enter on the input channel (i_valid / o_stall) with column,
// row, depth and colour; each yields exactly one point word on the output
// channel (o_valid / i_stall). A depth of zero yields an all-zero word with
// o_point_valid low. A word leaves at the earliest after passing through five
// register stages (offset, depth product, split reciprocal products, rounding
// sum, saturation into the output register). Throughput is one word per
// cycle while the receiver does not stall. When the receiver stalls, the
// word in the output register holds and earlier stages keep filling empty
// slots; o_stall rises only once all five stages hold words. Reset clears
// all stage valid bits and loads the default principal point and
// reciprocal focal lengths. Registers: 0 center_x_q4, 1 center_y_q4,
// 2 recip_focal_x, 3 recip_focal_y, at byte addresses 0, 4, 8, 12; write
// them only while idle.
module depth_pixel_backprojection_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [dpbp_pkg::ADDR_W-1:0]     paddr,
    input  logic [dpbp_pkg::DATA_W-1:0]     pwdata,
    output logic [dpbp_pkg::DATA_W-1:0]     prdata,
    output logic                            pready,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [dpbp_pkg::COORD_BITS-1:0] i_pixel_col,
    input  logic [dpbp_pkg::COORD_BITS-1:0] i_pixel_row,
    input  logic [dpbp_pkg::DEPTH_BITS-1:0] i_depth_mm,
    input  logic [dpbp_pkg::COLOR_W-1:0]    i_blue_in,
    input  logic [dpbp_pkg::COLOR_W-1:0]    i_green_in,
    input  logic [dpbp_pkg::COLOR_W-1:0]    i_red_in,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic                            o_point_valid,
    output logic signed [dpbp_pkg::COORD_W-1:0] o_x_mm,
    output logic signed [dpbp_pkg::COORD_W-1:0] o_y_mm,
    output logic [dpbp_pkg::Z_W-1:0]        o_z_mm,
    output logic [dpbp_pkg::COLOR_W-1:0]    o_red_out,
    output logic [dpbp_pkg::COLOR_W-1:0]    o_green_out,
    output logic [dpbp_pkg::COLOR_W-1:0]    o_blue_out
);
    import dpbp_pkg::*;

    logic [CENTER_W-1:0] r_center_x;
    logic [CENTER_W-1:0] r_center_y;
    logic [RECIP_W-1:0]  r_recip_x;
    logic [RECIP_W-1:0]  r_recip_y;

    logic [N_STAGES-1:0] r_v;
    logic [N_STAGES-1:0] w_en;
    t_side               r_side [N_STAGES];
    t_side               w_side_in;
    logic                w_wr;
    logic [1:0]          w_idx;
    logic                w_pv;
    logic [COORD_W-1:0]  w_x;
    logic [COORD_W-1:0]  w_y;

    // config port
    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite & pready;
    assign w_idx  = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_x <= RST_CENTER_X;
            r_center_y <= RST_CENTER_Y;
            r_recip_x  <= RST_RECIP_X;
            r_recip_y  <= RST_RECIP_Y;
        end else if (w_wr) begin
            case (w_idx)
                REG_CENTER_X: r_center_x <= pwdata[CENTER_W-1:0];
                REG_CENTER_Y: r_center_y <= pwdata[CENTER_W-1:0];
                REG_RECIP_X:  r_recip_x  <= pwdata[RECIP_W-1:0];
                REG_RECIP_Y:  r_recip_y  <= pwdata[RECIP_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_CENTER_X: prdata = DATA_W'(r_center_x);
            REG_CENTER_Y: prdata = DATA_W'(r_center_y);
            REG_RECIP_X:  prdata = DATA_W'(r_recip_x);
            REG_RECIP_Y:  prdata = DATA_W'(r_recip_y);
            default:      prdata = '0;
        endcase
    end

    // flow control: a stage loads when empty or when the next one moves
    always_comb begin
        w_en[N_STAGES-1] = !r_v[N_STAGES-1] || !i_stall;
        for (int k = N_STAGES - 2; k >= 0; k--) begin
            w_en[k] = !r_v[k] || w_en[k+1];
        end
    end

    assign o_stall = !w_en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_en[0]) begin
                r_v[0] <= i_valid;
            end
            for (int k = 1; k < N_STAGES; k++) begin
                if (w_en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // side band: valid flag, z and colour (zeroed for invalid depth)
    assign w_pv = i_depth_mm != '0;

    always_comb begin
        w_side_in.pv    = w_pv;
        w_side_in.z     = sat_depth(i_depth_mm);
        w_side_in.red   = w_pv ? i_red_in   : '0;
        w_side_in.green = w_pv ? i_green_in : '0;
        w_side_in.blue  = w_pv ? i_blue_in  : '0;
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_side[0] <= w_side_in;
        end
        for (int k = 1; k < N_STAGES; k++) begin
            if (w_en[k]) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    dpbp_axis u_axis_x (
        .i_clk    (i_clk),
        .i_en     (w_en),
        .i_pix    (i_pixel_col),
        .i_depth  (i_depth_mm),
        .i_center (r_center_x),
        .i_recip  (r_recip_x),
        .o_coord  (w_x)
    );

    dpbp_axis u_axis_y (
        .i_clk    (i_clk),
        .i_en     (w_en),
        .i_pix    (i_pixel_row),
        .i_depth  (i_depth_mm),
        .i_center (r_center_y),
        .i_recip  (r_recip_y),
        .o_coord  (w_y)
    );

    assign o_valid       = r_v[N_STAGES-1];
    assign o_point_valid = r_side[N_STAGES-1].pv;
    assign o_x_mm        = w_x;
    assign o_y_mm        = w_y;
    assign o_z_mm        = r_side[N_STAGES-1].z;
    assign o_red_out     = r_side[N_STAGES-1].red;
    assign o_green_out   = r_side[N_STAGES-1].green;
    assign o_blue_out    = r_side[N_STAGES-1].blue;

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_point_valid |-> o_x_mm == '0 && o_y_mm == '0 && o_z_mm == '0
            && o_red_out == '0 && o_green_out == '0 && o_blue_out == '0)
        else $error("invalid point carries nonzero data");

    a_valid_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_point_valid |-> o_z_mm != '0)
        else $error("valid point with zero depth");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> &r_v)
        else $error("input stalled with an empty stage");

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> r_v[0])
        else $error("accepted word not captured in first stage");

endmodule

// File: verif/depth_pixel_backprojection_unit_tb.sv
// Self-checking testbench for depth_pixel_backprojection_unit: random and corner pixels
// against an in-bench back-projection predictor, with random stalls on both channels.
// Depends on dpbp_pkg and the unit's RTL.
module depth_pixel_backprojection_unit_tb;
    import dpbp_pkg::*;

    localparam int RESET_CYCLES    = 12;
    localparam int IDLE_PCT        = 16;
    localparam int HOLD_CYCLES     = 60;
    localparam int DRAIN_CYCLES    = 8;
    localparam int STUCK_LIMIT     = 1000;
    localparam int ITEMS_PER_PHASE = 200;

    typedef struct packed {
        logic [COORD_BITS-1:0] col;
        logic [COORD_BITS-1:0] row;
        logic [DEPTH_BITS-1:0] depth;
        logic [COLOR_W-1:0]    blue;
        logic [COLOR_W-1:0]    green;
        logic [COLOR_W-1:0]    red;
    } pixel_t;

    typedef struct packed {
        logic                      pv;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic [Z_W-1:0]            z;
        logic [COLOR_W-1:0]        red;
        logic [COLOR_W-1:0]        green;
        logic [COLOR_W-1:0]        blue;
    } point_t;

    logic                  i_clk   = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [ADDR_W-1:0]     paddr   = '0;
    logic [DATA_W-1:0]     pwdata  = '0;
    logic [DATA_W-1:0]     prdata;
    logic                  pready;
    logic                  i_valid = 1'b0;
    logic                  o_stall;
    logic [COORD_BITS-1:0] i_pixel_col = '0;
    logic [COORD_BITS-1:0] i_pixel_row = '0;
    logic [DEPTH_BITS-1:0] i_depth_mm  = '0;
    logic [COLOR_W-1:0]    i_blue_in   = '0;
    logic [COLOR_W-1:0]    i_green_in  = '0;
    logic [COLOR_W-1:0]    i_red_in    = '0;
    logic                  o_valid;
    logic                  i_stall = 1'b0;
    logic                  o_point_valid;
    logic signed [COORD_W-1:0] o_x_mm;
    logic signed [COORD_W-1:0] o_y_mm;
    logic [Z_W-1:0]        o_z_mm;
    logic [COLOR_W-1:0]    o_red_out;
    logic [COLOR_W-1:0]    o_green_out;
    logic [COLOR_W-1:0]    o_blue_out;

    // camera setting as last written
    logic [CENTER_W-1:0] cam_cx = RST_CENTER_X;
    logic [CENTER_W-1:0] cam_cy = RST_CENTER_Y;
    logic [RECIP_W-1:0]  cam_rx = RST_RECIP_X;
    logic [RECIP_W-1:0]  cam_ry = RST_RECIP_Y;

    pixel_t pixel_q[$];
    point_t point_q[$];
    pixel_t cur_px;

    logic quiet_on    = 1'b0;
    logic pressure_on = 1'b0;
    int   hold_cnt     = 0;
    int   stuck_cycles = 0;
    int   mismatch_cnt = 0;
    int   cfg_err_cnt  = 0;
    int   pixels_sent  = 0;
    int   points_seen  = 0;
    int   invalid_seen = 0;
    int   cam_settings = 0;

    depth_pixel_backprojection_unit u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_pixel_col   (i_pixel_col),
        .i_pixel_row   (i_pixel_row),
        .i_depth_mm    (i_depth_mm),
        .i_blue_in     (i_blue_in),
        .i_green_in    (i_green_in),
        .i_red_in      (i_red_in),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_point_valid (o_point_valid),
        .o_x_mm        (o_x_mm),
        .o_y_mm        (o_y_mm),
        .o_z_mm        (o_z_mm),
        .o_red_out     (o_red_out),
        .o_green_out   (o_green_out),
        .o_blue_out    (o_blue_out)
    );

    always #1 i_clk = ~i_clk;

    // (pix - c) * depth / f in mm, halves away from zero, clamped to 32 bits
    function automatic logic signed [COORD_W-1:0] axis_mm(
        input logic [COORD_BITS-1:0] pix,
        input logic [CENTER_W-1:0]   c_q4,
        input logic [DEPTH_BITS-1:0] depth,
        input logic [RECIP_W-1:0]    recip
    );
        logic [63:0] p16;
        logic [63:0] mag;
        logic [63:0] r;
        logic        neg;
        p16 = 64'(pix) << 4;
        neg = p16 < 64'(c_q4);
        mag = neg ? (64'(c_q4) - p16) : (p16 - 64'(c_q4));
        r   = (mag * 64'(depth) * 64'(recip) + (64'd1 << 27)) >> 28;
        if (neg) begin
            if (r > 64'h8000_0000) r = 64'h8000_0000;
            r = 64'd0 - r;
        end else if (r > 64'h7FFF_FFFF) begin
            r = 64'h7FFF_FFFF;
        end
        return r[COORD_W-1:0];
    endfunction

    function automatic point_t project_pixel(input pixel_t px);
        point_t pt;
        pt = '0;
        if (px.depth != '0) begin
            pt.pv    = 1'b1;
            pt.x     = axis_mm(px.col, cam_cx, px.depth, cam_rx);
            pt.y     = axis_mm(px.row, cam_cy, px.depth, cam_ry);
            pt.z     = (64'(px.depth) > 64'hFFFF) ? '1 : Z_W'(px.depth);
            pt.red   = px.red;
            pt.green = px.green;
            pt.blue  = px.blue;
        end
        return pt;
    endfunction

    task automatic push_px(input int col, input int row, input int depth,
                           input int b, input int g, input int r);
        pixel_t px;
        px.col   = COORD_BITS'(col);
        px.row   = COORD_BITS'(row);
        px.depth = DEPTH_BITS'(depth);
        px.blue  = COLOR_W'(b);
        px.green = COLOR_W'(g);
        px.red   = COLOR_W'(r);
        pixel_q.push_back(px);
    endtask

    task automatic push_random(input int n);
        pixel_t px;
        int     sel;
        repeat (n) begin
            px  = pixel_t'({$urandom, $urandom});
            sel = $urandom_range(99);
            if (sel < 8)       px.depth = '0;
            else if (sel < 12) px.depth = '1;
            else if (sel < 20) px.depth = DEPTH_BITS'($urandom_range(1, 15));
            pixel_q.push_back(px);
        end
    endtask

    task automatic drain();
        while (pixel_q.size() != 0 || i_valid || point_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // write one register with junk in the unused upper bits, then read it back
    task automatic cfg_write(input logic [1:0] idx, input logic [RECIP_W-1:0] value);
        logic [DATA_W-1:0] data;
        logic [DATA_W-1:0] want;
        data = $urandom;
        want = '0;
        case (idx)
            REG_CENTER_X: begin
                data[CENTER_W-1:0] = value[CENTER_W-1:0];
                cam_cx = value[CENTER_W-1:0];
                want = DATA_W'(cam_cx);
            end
            REG_CENTER_Y: begin
                data[CENTER_W-1:0] = value[CENTER_W-1:0];
                cam_cy = value[CENTER_W-1:0];
                want = DATA_W'(cam_cy);
            end
            REG_RECIP_X: begin
                data[RECIP_W-1:0] = value;
                cam_rx = value;
                want = DATA_W'(cam_rx);
            end
            default: begin
                data[RECIP_W-1:0] = value;
                cam_ry = value;
                want = DATA_W'(cam_ry);
            end
        endcase
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({idx, 2'b00});
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        if (prdata !== want) begin
            $error("register %0d readback: expected %0h, got %0h", idx, want, prdata);
            cfg_err_cnt++;
        end
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic cfg_set(input int cx, input int cy, input int rx, input int ry);
        cfg_write(REG_CENTER_X, RECIP_W'(cx));
        cfg_write(REG_CENTER_Y, RECIP_W'(cy));
        cfg_write(REG_RECIP_X, RECIP_W'(rx));
        cfg_write(REG_RECIP_Y, RECIP_W'(ry));
        cam_settings++;
    endtask

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_cnt++;
        end
    endtask

    // pixel driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                point_q.push_back(project_pixel(cur_px));
                pixels_sent++;
            end
            if (!i_valid || !o_stall) begin
                if (pixel_q.size() != 0 &&
                    (quiet_on || pressure_on || $urandom_range(99) >= IDLE_PCT)) begin
                    cur_px = pixel_q.pop_front();
                    i_valid     <= 1'b1;
                    i_pixel_col <= cur_px.col;
                    i_pixel_row <= cur_px.row;
                    i_depth_mm  <= cur_px.depth;
                    i_blue_in   <= cur_px.blue;
                    i_green_in  <= cur_px.green;
                    i_red_in    <= cur_px.red;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // point monitor and receiver stall
    always @(posedge i_clk) begin
        point_t want;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (point_q.size() == 0) begin
                    $error("point word with nothing expected");
                    mismatch_cnt++;
                end else begin
                    want = point_q.pop_front();
                    check_field("point_valid", want.pv, o_point_valid);
                    check_field("x_mm", want.x, o_x_mm);
                    check_field("y_mm", want.y, o_y_mm);
                    check_field("z_mm", want.z, o_z_mm);
                    check_field("red_out", want.red, o_red_out);
                    check_field("green_out", want.green, o_green_out);
                    check_field("blue_out", want.blue, o_blue_out);
                    points_seen++;
                    if (!want.pv) invalid_seen++;
                end
            end
            if (pressure_on && hold_cnt < HOLD_CYCLES) begin
                hold_cnt++;
                i_stall <= 1'b1;
            end else begin
                i_stall <= !quiet_on && !pressure_on && ($urandom_range(99) < IDLE_PCT);
            end
        end
    end

    // watchdog on cycles without any accepted word
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles == STUCK_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset setting: invalid depth, field extremes, near the principal point
        push_px(0, 0, 0, 255, 255, 255);
        push_px(4095, 4095, 0, 0, 0, 0);
        push_px(0, 0, 65535, 255, 0, 255);
        push_px(4095, 4095, 65535, 255, 255, 255);
        push_px(4095, 0, 1, 8'h01, 8'h80, 8'h7F);
        push_px(0, 4095, 65535, 0, 255, 0);
        push_px(243, 137, 1000, 1, 2, 3);
        push_random(ITEMS_PER_PHASE);
        drain();

        // largest magnitudes of both signs
        cfg_set(0, 65535, 1 << 24, 1);
        push_px(4095, 0, 65535, 0, 0, 0);
        push_px(0, 4095, 65535, 255, 255, 255);
        push_px(4095, 4095, 65535, 170, 85, 170);
        push_random(ITEMS_PER_PHASE);
        drain();

        quiet_on = 1'b1;
        cfg_set(65535, 0, 1, 1 << 24);
        push_px(4095, 0, 65535, 0, 0, 0);
        push_px(0, 4095, 65535, 255, 255, 255);
        push_px(4095, 4095, 65535, 85, 170, 85);
        push_random(ITEMS_PER_PHASE);
        drain();
        quiet_on = 1'b0;

        // exact halves below zero, and zero offsets
        cfg_set(16, 16, 1 << 23, 1 << 23);
        push_px(0, 0, 1, 10, 20, 30);
        push_px(1, 1, 1, 40, 50, 60);
        push_px(0, 1, 3, 70, 80, 90);
        push_px(1, 0, 3, 100, 110, 120);
        push_random(ITEMS_PER_PHASE);
        drain();

        // receiver holds off while pixels keep coming
        pressure_on = 1'b1;
        cfg_set(RST_CENTER_X, RST_CENTER_Y, RST_RECIP_X, RST_RECIP_Y);
        push_random(ITEMS_PER_PHASE);
        drain();
        pressure_on = 1'b0;

        repeat (3) begin
            cfg_set($urandom_range(0, 65535), $urandom_range(0, 65535),
                    $urandom_range(1, 1 << 24), $urandom_range(1, 1 << 24));
            push_random(ITEMS_PER_PHASE);
            drain();
        end

        $display("%0d pixels driven over %0d camera settings; %0d points checked, %0d invalid",
                 pixels_sent, cam_settings + 1, points_seen, invalid_seen);
        if (mismatch_cnt == 0 && cfg_err_cnt == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
